@@ design/mpfd_pkg.sv @@
package mpfd_pkg;

    typedef enum logic [2:0] {
        OP_FILL    = 3'd0,
        OP_PIXEL   = 3'd1,
        OP_RECT    = 3'd2,
        OP_BLIT    = 3'd3,
        OP_READ    = 3'd4,
        OP_CLAIM   = 3'd5,
        OP_RESTORE = 3'd6,
        OP_NONE    = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_RD,
        ST_WR,
        ST_OUT
    } t_state;

    localparam int unsigned STORE_AW = 10;

endpackage

@@ design/mpfd_ram.sv @@
module mpfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/mono_page_framebuffer_draw.sv @@
// Channel | Dir | tdata fields (low bit up)                                   | tuser
// s_axis  | in  | op,fill_value,col_first,col_last,row_first,row_last,        | -
//         |     | image_byte,image_col,image_page,invert,page_sel (52b->56b)  |
// m_axis  | out | status,read_data,dirty_mask (17b->24b)                      | -
// Pixel: one read-modify-write on the store port; blit: one or two; read: one store read.
// Rectangle: one read-modify-write per store byte touched; fill all: writes all 1024 store bytes.
// Reset runs a clearing pass over all 1024 store bytes; no transaction taken then.
// One item in flight; a held result blocks the next item until taken.
module mono_page_framebuffer_draw #(
    parameter int COLUMNS = 128,
    parameter int ROWS    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // op,fill_value,col_first,col_last,row_first,row_last,
                                       // image_byte,image_col,image_page,invert,page_sel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // status,read_data,dirty_mask
);
    import mpfd_pkg::*;

    localparam int PAGES = (ROWS + 7) / 8;
    localparam int DEPTH = 1 << STORE_AW;

    t_state r_state, n_state;
    logic [STORE_AW-1:0] r_addr, n_addr;
    logic [2:0]  r_op, n_op;
    logic        r_fill, n_fill;
    logic [6:0]  r_c0, n_c0, r_c1, n_c1, r_col, n_col;
    logic [5:0]  r_r0, n_r0, r_r1, n_r1;
    logic [2:0]  r_page, n_page;
    logic [7:0]  r_byte, n_byte, r_spill, n_spill;
    logic        r_second, n_second, r_has2, n_has2;
    logic [7:0]  r_dirty, n_dirty;
    logic        r_status, n_status;
    logic [7:0]  r_rdata, n_rdata, r_before, n_before;

    logic                we;
    logic [STORE_AW-1:0] waddr, raddr;
    logic [7:0]          wdata, rdata_mem;

    mpfd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata_mem)
    );

    logic [2:0] i_op, i_page_sel, i_image_page;
    logic       i_fill, i_invert;
    logic [6:0] i_c0, i_c1, i_image_col;
    logic [5:0] i_r0, i_r1;
    logic [7:0] i_image_byte, img;
    logic [7:0] col_sum;
    logic [3:0] tgt;
    logic [6:0] vis;
    logic [2:0] off;
    logic [15:0] shifted;
    logic [7:0] mask;

    assign i_op         = s_axis_tdata[2:0];
    assign i_fill       = s_axis_tdata[3];
    assign i_c0         = s_axis_tdata[10:4];
    assign i_c1         = s_axis_tdata[17:11];
    assign i_r0         = s_axis_tdata[23:18];
    assign i_r1         = s_axis_tdata[29:24];
    assign i_image_byte = s_axis_tdata[37:30];
    assign i_image_col  = s_axis_tdata[44:38];
    assign i_image_page = s_axis_tdata[47:45];
    assign i_invert     = s_axis_tdata[48];
    assign i_page_sel   = s_axis_tdata[51:49];

    assign img     = i_invert ? ~i_image_byte : i_image_byte;
    assign off     = i_r0[2:0];
    assign shifted = {8'd0, img} << off;
    assign col_sum = {1'b0, i_c0} + {1'b0, i_image_col};
    assign tgt     = {1'b0, i_r0[5:3]} + {1'b0, i_image_page};
    assign vis     = 7'((ROWS - 32'(i_r0) + 7) / 8);

    always_comb begin
        mask = 8'hFF;
        if (r_page == r_r0[5:3]) mask = mask & (8'hFF << r_r0[2:0]);
        if (r_page == r_r1[5:3]) mask = mask & (8'hFF >> (3'd7 - r_r1[2:0]));
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {7'd0, r_before, r_rdata, r_status};

    always_comb begin
        n_state = r_state; n_addr = r_addr; n_op = r_op; n_fill = r_fill;
        n_c0 = r_c0; n_c1 = r_c1; n_col = r_col; n_r0 = r_r0; n_r1 = r_r1;
        n_page = r_page; n_byte = r_byte; n_spill = r_spill;
        n_second = r_second; n_has2 = r_has2; n_dirty = r_dirty;
        n_status = r_status; n_rdata = r_rdata; n_before = r_before;
        case (r_state)
            ST_CLEAR: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == STORE_AW'(DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op = i_op; n_fill = i_fill; n_c0 = i_c0; n_c1 = i_c1;
                    n_r0 = i_r0; n_r1 = i_r1;
                    n_before = r_dirty; n_status = 1'b0; n_rdata = 8'd0;
                    n_second = 1'b0; n_has2 = 1'b0;
                    n_state = ST_OUT;
                    case (t_op'(i_op))
                        OP_FILL: begin
                            n_addr = '0; n_state = ST_WALK;
                            n_dirty = 8'((1 << PAGES) - 1);
                        end
                        OP_PIXEL: begin
                            if (32'(i_c0) >= COLUMNS || 32'(i_r0) >= ROWS) begin
                                n_status = 1'b1;
                            end else begin
                                n_page = i_r0[5:3]; n_col = i_c0;
                                n_byte = 8'd1 << i_r0[2:0];
                                n_dirty = r_dirty | (8'd1 << i_r0[5:3]);
                                n_state = ST_RD;
                            end
                        end
                        OP_RECT: begin
                            if (32'(i_c0) >= COLUMNS || 32'(i_c1) >= COLUMNS ||
                                32'(i_r0) >= ROWS || 32'(i_r1) >= ROWS ||
                                i_c0 > i_c1 || i_r0 > i_r1) begin
                                n_status = 1'b1;
                            end else begin
                                n_page = i_r0[5:3]; n_col = i_c0;
                                n_state = ST_RD;
                                for (int p = 0; p < 8; p++) begin
                                    if (3'(p) >= i_r0[5:3] && 3'(p) <= i_r1[5:3])
                                        n_dirty[p] = 1'b1;
                                end
                            end
                        end
                        OP_BLIT: begin
                            if (32'(i_c0) >= COLUMNS || 32'(i_r0) >= ROWS) begin
                                n_status = 1'b1;
                            end else if (32'(col_sum) < COLUMNS &&
                                         {4'd0, i_image_page} < vis &&
                                         32'(tgt) < PAGES) begin
                                n_col = col_sum[6:0]; n_page = tgt[2:0];
                                n_byte = shifted[7:0]; n_spill = shifted[15:8];
                                n_fill = 1'b1;
                                n_dirty[tgt[2:0]] = 1'b1;
                                if (off != 3'd0 && 32'(tgt) + 1 < PAGES) begin
                                    n_has2 = 1'b1;
                                    n_dirty[tgt[2:0] + 3'd1] = 1'b1;
                                end
                                n_state = ST_RD;
                            end
                        end
                        OP_READ: begin
                            if (32'(i_page_sel) >= PAGES || 32'(i_c0) >= COLUMNS) begin
                                n_status = 1'b1;
                            end else begin
                                n_page = i_page_sel; n_col = i_c0; n_state = ST_RD;
                            end
                        end
                        OP_CLAIM: begin
                            if (32'(i_page_sel) >= PAGES) n_status = 1'b1;
                            else n_dirty[i_page_sel] = 1'b0;
                        end
                        OP_RESTORE: begin
                            if (32'(i_page_sel) >= PAGES) n_status = 1'b1;
                            else n_dirty[i_page_sel] = 1'b1;
                        end
                        default: n_status = 1'b1;
                    endcase
                end
            end
            ST_WALK: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == STORE_AW'(DEPTH - 1)) n_state = ST_OUT;
            end
            ST_RD: n_state = ST_WR;
            ST_WR: begin
                n_state = ST_OUT;
                if (t_op'(r_op) == OP_READ) begin
                    n_rdata = rdata_mem;
                end else if (t_op'(r_op) == OP_RECT) begin
                    n_state = ST_RD;
                    if (r_col != r_c1) begin
                        n_col = r_col + 1'b1;
                    end else if (r_page != r_r1[5:3]) begin
                        n_col = r_c0; n_page = r_page + 1'b1;
                    end else begin
                        n_state = ST_OUT;
                    end
                end else if (t_op'(r_op) == OP_BLIT && r_has2 && !r_second) begin
                    n_second = 1'b1; n_page = r_page + 1'b1; n_byte = r_spill;
                    n_state = ST_RD;
                end
            end
            ST_OUT: if (m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    logic [7:0] bits;
    always_comb begin
        raddr = STORE_AW'(32'(r_page) * COLUMNS + 32'(r_col));
        we    = 1'b0;
        waddr = r_addr;
        wdata = 8'd0;
        bits  = (t_op'(r_op) == OP_RECT) ? mask : r_byte;
        case (r_state)
            ST_CLEAR: we = 1'b1;
            ST_WALK: begin
                we = 1'b1; wdata = r_fill ? 8'hFF : 8'h00;
            end
            ST_WR: begin
                we    = (t_op'(r_op) != OP_READ);
                waddr = raddr;
                wdata = r_fill ? (rdata_mem | bits) : (rdata_mem & ~bits);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
            r_dirty <= 8'd0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_dirty <= n_dirty;
        end
        r_op <= n_op; r_fill <= n_fill; r_c0 <= n_c0; r_c1 <= n_c1; r_col <= n_col;
        r_r0 <= n_r0; r_r1 <= n_r1; r_page <= n_page;
        r_byte <= n_byte; r_spill <= n_spill; r_second <= n_second; r_has2 <= n_has2;
        r_status <= n_status; r_rdata <= n_rdata; r_before <= n_before;
    end
endmodule

@@ design/mpfd_checker.sv @@
module mpfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input open while result pending");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:17] == 7'd0)
        else $error("padding not zero");
    a_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
        else $error("read data on error");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("accepting during clear");
endmodule

bind mono_page_framebuffer_draw mpfd_checker u_chk (.*);
